@@ rtl/core/rtip_pkg.sv @@
package rtip_pkg;

	localparam int VALUE_BITS = 32;
	localparam int LIMIT_BITS = 31;
	localparam int CNT_BITS = $clog2(VALUE_BITS);
	localparam int EXT_BITS = (VALUE_BITS > LIMIT_BITS) ? VALUE_BITS : LIMIT_BITS;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [LIMIT_BITS-1:0] limit_t;
	typedef logic [EXT_BITS-1:0]   ext_t;

	localparam value_t VALUE_TOP   = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam limit_t LIMIT_RESET = limit_t'(65535);

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] number_a;
		logic signed [VALUE_BITS-1:0] number_b;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] out_a;
		logic signed [VALUE_BITS-1:0] out_b;
		logic                         both_zero;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_CHECK,
		S_DIV,
		S_SCALE,
		S_MULT,
		S_FINAL
	} state_t;

	// Request to the shared divide / multiply-accumulate unit
	typedef struct packed {
		logic   start;
		value_t dividend;
		value_t divisor;
		value_t mul_x;
		value_t mul_y;
	} dm_req_t;

	typedef struct packed {
		logic   done;
		value_t rem;
		value_t acc_x;
		value_t acc_y;
	} dm_rsp_t;

	// Add, saturating to all ones
	function automatic value_t sat_add(value_t a, value_t b);
		logic [VALUE_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[VALUE_BITS] ? '1 : s[VALUE_BITS-1:0];
	endfunction

	// Clamp the limit register to the largest positive output value
	function automatic value_t eff_limit(limit_t lim);
		ext_t l_ext;
		ext_t top_ext;
		l_ext   = ext_t'(lim);
		top_ext = ext_t'(VALUE_TOP);
		return (l_ext > top_ext) ? value_t'(top_ext) : value_t'(l_ext);
	endfunction

	function automatic value_t magnitude(value_t raw);
		return raw[VALUE_BITS-1] ? value_t'(~raw + value_t'(1)) : raw;
	endfunction

endpackage

@@ rtl/core/rtip_divmac.sv @@
module rtip_divmac (
	input  logic              clk,
	input  logic              arst_n,
	input  rtip_pkg::dm_req_t req,
	output rtip_pkg::dm_rsp_t rsp
);

	localparam int W  = rtip_pkg::VALUE_BITS;
	localparam int CW = rtip_pkg::CNT_BITS;
	localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

	logic            busy_q;
	logic            done_q;
	logic [CW-1:0]   cnt_q;
	rtip_pkg::value_t dvd_q;
	rtip_pkg::value_t dsr_q;
	rtip_pkg::value_t rem_q;
	rtip_pkg::value_t x_q;
	rtip_pkg::value_t y_q;
	rtip_pkg::value_t acc_x_q;
	rtip_pkg::value_t acc_y_q;

	logic [W:0]       partial;
	logic [W:0]       diff;
	logic             ge;
	rtip_pkg::value_t rem_nx;
	logic             launch;

	// acc * 2 + add, saturating to all ones
	function automatic rtip_pkg::value_t dbl_add(rtip_pkg::value_t acc,
		rtip_pkg::value_t add);
		logic [W+1:0] s;
		s = {1'b0, acc, 1'b0} + {2'b00, add};
		return (s[W+1:W] != 2'b00) ? '1 : s[W-1:0];
	endfunction

	// One restoring step; the quotient bit also drives both shift-add products
	always_comb begin
		partial = {rem_q, dvd_q[W-1]};
		diff    = partial - {1'b0, dsr_q};
		ge      = (partial >= {1'b0, dsr_q});
		rem_nx  = ge ? diff[W-1:0] : partial[W-1:0];
		launch  = req.start && !busy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (launch) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (launch) begin
			dvd_q   <= req.dividend;
			dsr_q   <= req.divisor;
			rem_q   <= '0;
			x_q     <= req.mul_x;
			y_q     <= req.mul_y;
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (busy_q) begin
			dvd_q   <= {dvd_q[W-2:0], 1'b0};
			rem_q   <= rem_nx;
			acc_x_q <= dbl_add(acc_x_q, ge ? x_q : '0);
			acc_y_q <= dbl_add(acc_y_q, ge ? y_q : '0);
		end
	end

	assign rsp.done  = done_q;
	assign rsp.rem   = rem_q;
	assign rsp.acc_x = acc_x_q;
	assign rsp.acc_y = acc_y_q;

	a_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divmac started while busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divmac done held for more than one cycle");

	a_done_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q)
		else $error("divmac finished without done");

endmodule

@@ rtl/core/ratio_to_integer_pair.sv @@
// Ratio to integer pair: approximates number_a : number_b by two integers of
// magnitude at most the limit register, via a continued-fraction expansion.
//
// Channels: in_* carries one beat {number_a, number_b}; out_* carries one beat
// {out_a, out_b, both_zero}. A beat moves on a rising edge with valid high and
// stall low. cfg_we writes cfg_data into the limit register; write it only
// while no beat is in flight.
//
// Datapath: one shared serial divider, one quotient bit per cycle, runs every
// Euclid step after the first and then the final scaling division. One beat
// is worked on at a time, so in_stall stays high until the result is in the
// output register.
//
// Reset: arst_n clears the sequencer, the output valid and sets the limit to
// 65535. A stalled result is held in the output register; the next input beat
// is still taken and worked on, and only its final write waits for the slot.
module ratio_to_integer_pair (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rtip_pkg::LIMIT_BITS-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  rtip_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output rtip_pkg::out_item_t          out_data
);

	localparam int W = rtip_pkg::VALUE_BITS;

	rtip_pkg::state_t  state_q;
	rtip_pkg::state_t  state_nx;
	rtip_pkg::limit_t  lim_q;
	rtip_pkg::value_t  lim_eff;

	// Operand capture
	rtip_pkg::value_t  mag_a_q;
	rtip_pkg::value_t  mag_b_q;
	logic              neg_a_q;
	logic              neg_b_q;
	logic              flip_q;
	logic              bz_q;

	// Convergents: p0/q0 newest, p2/q2 oldest
	rtip_pkg::value_t  p0_q, p1_q, p2_q;
	rtip_pkg::value_t  q0_q, q1_q, q2_q;
	rtip_pkg::value_t  dsr_q;
	rtip_pkg::value_t  rem_q;

	// Scaled pair, small side over large side
	rtip_pkg::value_t  res_num_q;
	rtip_pkg::value_t  res_den_q;

	logic                out_valid_q;
	rtip_pkg::out_item_t out_data_q;
	rtip_pkg::out_item_t out_w;
	logic                out_load;

	rtip_pkg::dm_req_t dm_req;
	rtip_pkg::dm_rsp_t dm_rsp;

	logic              flip_w;
	logic              eq_w;
	logic              both_zero_w;
	rtip_pkg::value_t  small_w;
	rtip_pkg::value_t  large_w;
	logic              q0_fits;
	logic              cont;
	rtip_pkg::value_t  big_w;
	rtip_pkg::value_t  res_a;
	rtip_pkg::value_t  res_b;

	rtip_divmac u_divmac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dm_req),
		.rsp    (dm_rsp)
	);

	always_comb begin
		lim_eff     = rtip_pkg::eff_limit(lim_q);
		flip_w      = (mag_a_q > mag_b_q);
		eq_w        = (mag_a_q == mag_b_q);
		both_zero_w = (mag_a_q == '0) && (mag_b_q == '0);
		small_w     = flip_w ? mag_b_q : mag_a_q;
		large_w     = flip_w ? mag_a_q : mag_b_q;
		q0_fits     = (q0_q <= lim_eff);
		// Keep expanding while a remainder is left and the denominator fits
		cont        = (rem_q != '0) && q0_fits;
		big_w       = (p1_q > q1_q) ? p1_q : q1_q;
	end

	// Sequencer: next state and unit requests
	always_comb begin
		state_nx = state_q;
		dm_req   = '0;
		out_load = 1'b0;
		case (state_q)
			rtip_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nx = rtip_pkg::S_SETUP;
				end
			end
			rtip_pkg::S_SETUP: begin
				state_nx = both_zero_w ? rtip_pkg::S_FINAL : rtip_pkg::S_CHECK;
			end
			rtip_pkg::S_CHECK: begin
				if (cont) begin
					dm_req.start    = 1'b1;
					dm_req.dividend = dsr_q;
					dm_req.divisor  = rem_q;
					dm_req.mul_x    = p0_q;
					dm_req.mul_y    = q0_q;
					state_nx        = rtip_pkg::S_DIV;
				end else begin
					state_nx = rtip_pkg::S_SCALE;
				end
			end
			rtip_pkg::S_DIV: begin
				if (dm_rsp.done) begin
					state_nx = rtip_pkg::S_CHECK;
				end
			end
			rtip_pkg::S_SCALE: begin
				if (big_w == '0) begin
					state_nx = rtip_pkg::S_FINAL;
				end else begin
					// limit / big, with both products formed on the way
					dm_req.start    = 1'b1;
					dm_req.dividend = lim_eff;
					dm_req.divisor  = big_w;
					dm_req.mul_x    = p1_q;
					dm_req.mul_y    = q1_q;
					state_nx        = rtip_pkg::S_MULT;
				end
			end
			rtip_pkg::S_MULT: begin
				if (dm_rsp.done) begin
					state_nx = rtip_pkg::S_FINAL;
				end
			end
			rtip_pkg::S_FINAL: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_nx = rtip_pkg::S_IDLE;
				end
			end
			default: begin
				state_nx = rtip_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtip_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= rtip_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			lim_q <= cfg_data;
		end
	end

	// Datapath registers, advanced by the sequencer state
	always_ff @(posedge clk) begin
		case (state_q)
			rtip_pkg::S_IDLE: begin
				if (in_valid) begin
					mag_a_q <= rtip_pkg::magnitude(in_data.number_a);
					mag_b_q <= rtip_pkg::magnitude(in_data.number_b);
					neg_a_q <= in_data.number_a[W-1];
					neg_b_q <= in_data.number_b[W-1];
				end
			end
			rtip_pkg::S_SETUP: begin
				// First Euclid step needs no divider: small / large is 0 or 1
				flip_q    <= flip_w;
				bz_q      <= both_zero_w;
				p1_q      <= rtip_pkg::value_t'(1);
				q1_q      <= '0;
				p0_q      <= eq_w ? rtip_pkg::value_t'(1) : '0;
				q0_q      <= rtip_pkg::value_t'(1);
				dsr_q     <= large_w;
				rem_q     <= eq_w ? '0 : small_w;
				res_num_q <= '0;
				res_den_q <= '0;
			end
			rtip_pkg::S_CHECK: begin
				if (cont) begin
					p2_q  <= p1_q;
					p1_q  <= p0_q;
					q2_q  <= q1_q;
					q1_q  <= q0_q;
					dsr_q <= rem_q;
				end else if (rem_q == '0 && q0_fits) begin
					// Exact expansion that fits: keep the newest convergent
					p1_q <= p0_q;
					q1_q <= q0_q;
				end
			end
			rtip_pkg::S_DIV: begin
				if (dm_rsp.done) begin
					rem_q <= dm_rsp.rem;
					p0_q  <= rtip_pkg::sat_add(dm_rsp.acc_x, p2_q);
					q0_q  <= rtip_pkg::sat_add(dm_rsp.acc_y, q2_q);
				end
			end
			rtip_pkg::S_SCALE: begin
				if (big_w == '0) begin
					res_num_q <= '0;
					res_den_q <= '0;
				end
			end
			rtip_pkg::S_MULT: begin
				if (dm_rsp.done) begin
					res_num_q <= dm_rsp.acc_x;
					res_den_q <= dm_rsp.acc_y;
				end
			end
			default: begin
			end
		endcase
	end

	// Undo the ordering, restore the signs
	always_comb begin
		res_a           = flip_q ? res_den_q : res_num_q;
		res_b           = flip_q ? res_num_q : res_den_q;
		out_w.out_a     = neg_a_q ? (rtip_pkg::value_t'(0) - res_a) : res_a;
		out_w.out_b     = neg_b_q ? (rtip_pkg::value_t'(0) - res_b) : res_b;
		out_w.both_zero = bz_q;
	end

	// Output register: hold the beat while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_w;
		end
	end

	assign in_stall  = (state_q != rtip_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.both_zero) |->
		(out_data_q.out_a == '0 && out_data_q.out_b == '0))
		else $error("both_zero beat with non-zero values");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		dm_rsp.done |-> (state_q == rtip_pkg::S_DIV || state_q == rtip_pkg::S_MULT))
		else $error("divider finished outside a wait state");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(out_data_q)))
		else $error("stalled output beat changed");

endmodule
